// ===== rtl/core/rhd_pkg.sv =====
package rhd_pkg;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_WORD = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_HEX2 = 3'd3,
        MODE_SKIP = 3'd4
    } rhd_mode_t;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // Offset that maps a lowercase hex letter to its value.
    localparam logic [7:0] HEX_LO_OFS = 8'h57;

    // Control words, first character in the top byte.
    localparam logic [55:0] KW_HTMLRTF = "htmlrtf";
    localparam logic [23:0] KW_PAR     = "par";
    localparam logic [23:0] KW_TAB     = "tab";

    // Number of word characters kept for keyword matching.
    localparam int PREFIX_LEN = 8;

    // Result queue between the parser and the output side.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // One queue entry: the results caused by one input byte.
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } rhd_rec_t;

endpackage

// ===== rtl/core/rhd_front.sv =====
module rhd_front #(
    parameter int WORD_MAX    = 63,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    output logic            rec_valid,
    output rhd_pkg::rhd_rec_t rec
);

    localparam int LEN_W = $clog2(WORD_MAX + 1);

    rhd_pkg::rhd_mode_t     mode_reg, mode_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [7:0]             hex_reg, hex_next;
    logic [DEPTH_WIDTH-1:0] depth_reg, depth_next;
    logic                   sup_reg, sup_next;
    logic                   nl_reg, nl_next;
    logic [7:0]             prefix_reg [rhd_pkg::PREFIX_LEN];

    logic                   is_word_char;
    logic                   pre_we;
    logic                   nl_emit;
    logic                   tx_emit;
    logic                   tb_en;
    logic [7:0]             tb_byte;
    logic [7:0]             digit;
    logic [7:0]             hex_val;
    logic [DEPTH_WIDTH-1:0] depth_dec;
    logic                   kw_htmlrtf;
    logic                   kw_par;
    logic                   kw_tab;

    // Character classes, keyword matches on the stored word prefix, hex digit values and the depth decrement.
    always_comb
    begin
        is_word_char = (in_byte >= rhd_pkg::CH_UP_A && in_byte <= rhd_pkg::CH_UP_Z)
                    || (in_byte >= rhd_pkg::CH_LO_A && in_byte <= rhd_pkg::CH_LO_Z)
                    || (in_byte >= rhd_pkg::CH_ZERO && in_byte <= rhd_pkg::CH_NINE)
                    || (in_byte == rhd_pkg::CH_MINUS);
        kw_htmlrtf = (len_reg >= LEN_W'(7))
                  && ({prefix_reg[0], prefix_reg[1], prefix_reg[2], prefix_reg[3],
                       prefix_reg[4], prefix_reg[5], prefix_reg[6]} == rhd_pkg::KW_HTMLRTF);
        kw_par = (len_reg == LEN_W'(3))
              && ({prefix_reg[0], prefix_reg[1], prefix_reg[2]} == rhd_pkg::KW_PAR);
        kw_tab = (len_reg == LEN_W'(3))
              && ({prefix_reg[0], prefix_reg[1], prefix_reg[2]} == rhd_pkg::KW_TAB);
        digit = (in_byte >= rhd_pkg::CH_LO_A) ? (in_byte - rhd_pkg::HEX_LO_OFS)
                                              : (in_byte - rhd_pkg::CH_ZERO);
        hex_val = {hex_reg[3:0], 4'b0000} + digit;
        depth_dec = (depth_reg != '0) ? (depth_reg - 1'b1) : depth_reg;
    end

    // Mode handling, then the plain-byte path that a text byte, a word delimiter
    // or a decoded hex byte may feed.
    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        hex_next   = hex_reg;
        depth_next = depth_reg;
        sup_next   = sup_reg;
        nl_next    = nl_reg;
        pre_we     = 1'b0;
        nl_emit    = 1'b0;
        tx_emit    = 1'b0;
        tb_en      = 1'b0;
        tb_byte    = in_byte;

        case (mode_reg)
            rhd_pkg::MODE_WORD:
            begin
                if (is_word_char)
                begin
                    if (len_reg < LEN_W'(WORD_MAX))
                    begin
                        pre_we   = (len_reg < LEN_W'(rhd_pkg::PREFIX_LEN));
                        len_next = len_reg + 1'b1;
                    end
                end
                else if (len_reg == '0)
                begin
                    mode_next = (in_byte == rhd_pkg::CH_QUOTE) ? rhd_pkg::MODE_HEX1
                                                               : rhd_pkg::MODE_TEXT;
                end
                else
                begin
                    mode_next = rhd_pkg::MODE_TEXT;
                    if (in_byte == rhd_pkg::CH_LBRACE)
                    begin
                        mode_next  = rhd_pkg::MODE_SKIP;
                        depth_next = DEPTH_WIDTH'(1);
                    end
                    else if (in_byte != rhd_pkg::CH_SPACE && in_byte != rhd_pkg::CH_SEMI)
                    begin
                        tb_en = 1'b1;
                    end
                    if (kw_htmlrtf)
                    begin
                        sup_next = !((len_reg >= LEN_W'(8)) && (prefix_reg[7] == rhd_pkg::CH_ZERO));
                    end
                    else if (kw_par)
                    begin
                        nl_emit = !nl_reg;
                        nl_next = 1'b1;
                    end
                    else if (kw_tab)
                    begin
                        tb_en = 1'b0;
                    end
                    len_next = '0;
                end
            end
            rhd_pkg::MODE_HEX1:
            begin
                hex_next  = digit;
                mode_next = rhd_pkg::MODE_HEX2;
            end
            rhd_pkg::MODE_HEX2:
            begin
                mode_next = rhd_pkg::MODE_TEXT;
                tb_byte   = hex_val;
                tb_en     = (hex_val != 8'h00);
            end
            rhd_pkg::MODE_SKIP:
            begin
                if (in_byte == rhd_pkg::CH_LBRACE)
                begin
                    if (depth_reg != '1)
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                end
                else if (in_byte == rhd_pkg::CH_RBRACE)
                begin
                    depth_next = depth_dec;
                    if (depth_dec == '0)
                    begin
                        mode_next = rhd_pkg::MODE_TEXT;
                    end
                end
            end
            default:
            begin
                tb_en = 1'b1;
            end
        endcase

        // Plain byte: a backslash opens a word, braces vanish, and printable
        // bytes pass unless suppressed.
        if (tb_en)
        begin
            mode_next = rhd_pkg::MODE_TEXT;
            if (tb_byte == rhd_pkg::CH_BSLASH)
            begin
                mode_next = rhd_pkg::MODE_WORD;
                len_next  = '0;
            end
            else if (tb_byte == rhd_pkg::CH_LBRACE || tb_byte == rhd_pkg::CH_RBRACE)
            begin
                tx_emit = 1'b0;
            end
            else if (!sup_next && tb_byte >= rhd_pkg::CH_SPACE)
            begin
                tx_emit = 1'b1;
                nl_next = 1'b0;
            end
        end
    end

    // Result record for the queue; a paragraph newline goes before the text byte.
    always_comb
    begin
        rec_valid  = nl_emit | tx_emit;
        rec.two    = nl_emit & tx_emit;
        rec.first  = nl_emit ? rhd_pkg::CH_NL : tb_byte;
        rec.second = tb_byte;
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rhd_pkg::MODE_TEXT;
            len_reg   <= '0;
            hex_reg   <= '0;
            depth_reg <= '0;
            sup_reg   <= 1'b0;
            nl_reg    <= 1'b1;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            hex_reg   <= hex_next;
            depth_reg <= depth_next;
            sup_reg   <= sup_next;
            nl_reg    <= nl_next;
        end
    end

    // Word prefix store; entries are only read below the word length.
    always_ff @(posedge clk)
    begin
        if (accept && pre_we)
        begin
            prefix_reg[len_reg[2:0]] <= in_byte;
        end
    end

`ifndef NO_ASSERTIONS
    // A skipped group always has an open brace to wait for.
    a_skip_depth: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == rhd_pkg::MODE_SKIP |-> depth_reg != '0)
        else $error("group skip with zero depth");

    // Two results only come from a paragraph break followed by text.
    a_two_needs_nl: assert property (@(posedge clk) disable iff (!rst_n)
        rec.two |-> mode_reg == rhd_pkg::MODE_WORD && rec.first == rhd_pkg::CH_NL)
        else $error("double result outside a control word");
`endif

endmodule

// ===== rtl/core/rhd_queue.sv =====
module rhd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  rhd_pkg::rhd_rec_t wr_rec,
    input  logic              rd_en,
    output rhd_pkg::rhd_rec_t rd_rec,
    output logic              q_empty,
    output logic              q_full
);

    rhd_pkg::rhd_rec_t             mem [rhd_pkg::Q_DEPTH];
    logic [rhd_pkg::Q_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [rhd_pkg::Q_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [rhd_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + rhd_pkg::Q_CNT_W'(wr_en) - rhd_pkg::Q_CNT_W'(rd_en);
        q_empty   = (cnt_reg == '0);
        q_full    = (cnt_reg == rhd_pkg::Q_CNT_W'(rhd_pkg::Q_DEPTH));
        rd_rec    = mem[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_rec;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("write into a full result queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("read from an empty result queue");
`endif

endmodule

// ===== rtl/core/rhd_back.sv =====
module rhd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rhd_pkg::rhd_rec_t head,
    input  logic              q_empty,
    input  logic              pop,
    output logic              rd_en,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              last_of_run
);

    logic phase_reg, phase_next;
    logic take;

    // Present the head entry one beat at a time; release it after its last beat.
    always_comb
    begin
        empty       = q_empty;
        take        = pop && !q_empty;
        out_byte    = phase_reg ? head.second : head.first;
        last_of_run = phase_reg || !head.two;
        rd_en       = take && last_of_run;
        phase_next  = phase_reg;
        if (take)
        begin
            phase_next = !last_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The second beat is only pending on a two-beat entry still in the queue.
    a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_empty && head.two)
        else $error("second beat without a two-beat entry");
`endif

endmodule

// ===== rtl/core/rtf_html_deencapsulator.sv =====
// Extracts HTML from an RTF stream that encapsulates it. One RTF byte may be
// pushed every clock cycle when not full; the parser handles it in that same
// cycle and, if it yields output, stores one entry of one or two HTML bytes
// in a four-entry result queue. The result side hands out one byte per pop,
// so a byte that yields a paragraph newline and a text byte needs two pops;
// last_of_run marks the final byte caused by one input byte. full rises only
// when the result queue holds four unread entries, so input stalls follow
// output stalls by at most four input bytes that produce results. Control
// words keep their first eight characters for keyword matching and count up
// to WORD_MAX characters; skipped groups nest up to 2**DEPTH_WIDTH - 1 levels.
module rtf_html_deencapsulator #(
    parameter int WORD_MAX    = 63,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic              accept;
    logic              rec_valid;
    rhd_pkg::rhd_rec_t rec;
    rhd_pkg::rhd_rec_t head;
    logic              q_empty;
    logic              q_full;
    logic              rd_en;

    // An input beat is taken whenever the queue has room.
    assign accept = push && !q_full;
    assign full   = q_full;

    rhd_front #(
        .WORD_MAX    (WORD_MAX),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    rhd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && rec_valid),
        .wr_rec  (rec),
        .rd_en   (rd_en),
        .rd_rec  (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    rhd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .rd_en       (rd_en),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
